/* design/tql_pkg.sv */
`timescale 1ns / 1ps

package tql_pkg;

	localparam int DEF_MAX_STATES  = 256;
	localparam int DEF_MAX_ACTIONS = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [8:0]  RST_STATES_IN_USE  = 9'd256;
	localparam logic [4:0]  RST_ACTIONS_IN_USE = 5'd16;
	localparam logic [15:0] RST_LEARNING_RATE  = 16'd6554;
	localparam logic [15:0] RST_DISCOUNT       = 16'd58982;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATES_IN_USE  = 2'd0,
		REG_ACTIONS_IN_USE = 2'd1,
		REG_LEARNING_RATE  = 2'd2,
		REG_DISCOUNT       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_TRAIN = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_BAD_STATE   = 2'd1,
		STS_BAD_NEXT    = 2'd2,
		STS_BAD_ACTION  = 2'd3
	} sts_code_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_DECIDE,
		FSM_SCAN,
		FSM_SCAN_END,
		FSM_RD_CUR,
		FSM_TARGET,
		FSM_SCALE,
		FSM_WRITE_BACK,
		FSM_WR_ENTRY,
		FSM_FINISH
	} fsm_t;

	typedef struct packed {
		logic [8:0]  states_in_use;
		logic [4:0]  actions_in_use;
		logic [15:0] learning_rate;
		logic [15:0] discount;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan_issue;
		logic rd_cur;
		logic target;
		logic scale;
		logic write_back;
		logic write_entry;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic err;
		req_t req;
	} dp_sts_t;

endpackage

/* design/tql_cfg.sv */
`timescale 1ns / 1ps

module tql_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tql_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tql_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tql_pkg::cfg_t                   cfg
);

	tql_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.states_in_use  <= tql_pkg::RST_STATES_IN_USE;
			cfg_q.actions_in_use <= tql_pkg::RST_ACTIONS_IN_USE;
			cfg_q.learning_rate  <= tql_pkg::RST_LEARNING_RATE;
			cfg_q.discount       <= tql_pkg::RST_DISCOUNT;
		end else if (cfg_write) begin
			case (tql_pkg::reg_idx_t'(cfg_index))
				tql_pkg::REG_STATES_IN_USE:  cfg_q.states_in_use  <= cfg_data[8:0];
				tql_pkg::REG_ACTIONS_IN_USE: cfg_q.actions_in_use <= cfg_data[4:0];
				tql_pkg::REG_LEARNING_RATE:  cfg_q.learning_rate  <= cfg_data;
				tql_pkg::REG_DISCOUNT:       cfg_q.discount       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/tql_ctrl.sv */
`timescale 1ns / 1ps

module tql_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tql_pkg::dp_sts_t  sts,
	output tql_pkg::cmd_t     cmd,
	output logic              busy
);

	tql_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tql_pkg::FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tql_pkg::FSM_CLEAR: begin
				if (sts.clear_last) state_d = tql_pkg::FSM_IDLE;
			end
			tql_pkg::FSM_IDLE: begin
				if (start) state_d = tql_pkg::FSM_DECIDE;
			end
			tql_pkg::FSM_DECIDE: begin
				if (sts.err) begin
					state_d = tql_pkg::FSM_FINISH;
				end else begin
					case (sts.req)
						tql_pkg::REQ_TRAIN: state_d = tql_pkg::FSM_SCAN;
						tql_pkg::REQ_QUERY: state_d = tql_pkg::FSM_SCAN;
						tql_pkg::REQ_WRITE: state_d = tql_pkg::FSM_WR_ENTRY;
						default:            state_d = tql_pkg::FSM_FINISH;
					endcase
				end
			end
			tql_pkg::FSM_SCAN: begin
				if (sts.scan_last) state_d = tql_pkg::FSM_SCAN_END;
			end
			tql_pkg::FSM_SCAN_END: begin
				if (sts.req == tql_pkg::REQ_TRAIN) state_d = tql_pkg::FSM_RD_CUR;
				else state_d = tql_pkg::FSM_FINISH;
			end
			tql_pkg::FSM_RD_CUR:     state_d = tql_pkg::FSM_TARGET;
			tql_pkg::FSM_TARGET:     state_d = tql_pkg::FSM_SCALE;
			tql_pkg::FSM_SCALE:      state_d = tql_pkg::FSM_WRITE_BACK;
			tql_pkg::FSM_WRITE_BACK: state_d = tql_pkg::FSM_FINISH;
			tql_pkg::FSM_WR_ENTRY:   state_d = tql_pkg::FSM_FINISH;
			tql_pkg::FSM_FINISH:     state_d = tql_pkg::FSM_IDLE;
			default:                 state_d = tql_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			tql_pkg::FSM_CLEAR:      cmd.clear = 1'b1;
			tql_pkg::FSM_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			tql_pkg::FSM_SCAN:       cmd.scan_issue  = 1'b1;
			tql_pkg::FSM_RD_CUR:     cmd.rd_cur      = 1'b1;
			tql_pkg::FSM_TARGET:     cmd.target      = 1'b1;
			tql_pkg::FSM_SCALE:      cmd.scale       = 1'b1;
			tql_pkg::FSM_WRITE_BACK: cmd.write_back  = 1'b1;
			tql_pkg::FSM_WR_ENTRY:   cmd.write_entry = 1'b1;
			tql_pkg::FSM_FINISH:     cmd.finish      = 1'b1;
			default: ;
		endcase
	end

endmodule

/* design/tql_dp.sv */
`timescale 1ns / 1ps

module tql_dp #(
	parameter int MAX_STATES  = tql_pkg::DEF_MAX_STATES,
	parameter int MAX_ACTIONS = tql_pkg::DEF_MAX_ACTIONS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tql_pkg::cfg_t       cfg,
	input  tql_pkg::cmd_t       cmd,
	output tql_pkg::dp_sts_t    sts,
	input  logic [1:0]          req_type,
	input  logic [7:0]          cur_state,
	input  logic [3:0]          taken_action,
	input  logic signed [15:0]  reward,
	input  logic [7:0]          following_state,
	input  logic signed [15:0]  entry_value,
	output logic                done,
	output logic [1:0]          status,
	output logic [3:0]          best_action,
	output logic signed [15:0]  best_value,
	output logic signed [15:0]  new_value
);

	localparam int SW    = $clog2(MAX_STATES);
	localparam int AW    = $clog2(MAX_ACTIONS);
	localparam int ADW   = SW + AW;
	localparam int DEPTH = 2 ** ADW;

	// request held for the whole job
	tql_pkg::req_t       req_q;
	logic [7:0]          s_q;
	logic [3:0]          a_q;
	logic [7:0]          ns_q;
	logic signed [15:0]  reward_q;
	logic signed [15:0]  entry_q;
	tql_pkg::sts_code_t  code_q;

	logic signed [15:0]  mem [DEPTH];
	logic signed [15:0]  rd_data_q;
	logic [ADW-1:0]      rd_addr;
	logic [ADW-1:0]      wr_addr;
	logic signed [15:0]  wr_data;
	logic                wr_en;

	logic [ADW-1:0]      clr_q;
	logic [AW-1:0]       idx_q;
	logic                cmp_vld_s1;
	logic [AW-1:0]       cmp_idx_s1;
	logic signed [15:0]  best_q;
	logic [AW-1:0]       best_idx_q;

	logic signed [32:0]  prod1_q;
	logic signed [15:0]  cur_q;
	logic signed [18:0]  diff_q;
	logic signed [35:0]  prod2_q;
	logic signed [15:0]  new_q;

	logic                done_q;
	logic [1:0]          status_q;
	logic [3:0]          best_action_q;
	logic signed [15:0]  best_value_q;
	logic signed [15:0]  new_value_q;

	// validity of the incoming request
	logic                s_ok, ns_ok, a_ok, na_ok;
	tql_pkg::sts_code_t  code_d;
	tql_pkg::req_t       req_in;

	assign req_in = tql_pkg::req_t'(req_type);
	assign s_ok  = (32'(cur_state) < 32'(cfg.states_in_use)) &&
		(32'(cur_state) < 32'(MAX_STATES));
	assign ns_ok = (32'(following_state) < 32'(cfg.states_in_use)) &&
		(32'(following_state) < 32'(MAX_STATES));
	assign a_ok  = (32'(taken_action) < 32'(cfg.actions_in_use)) &&
		(32'(taken_action) < 32'(MAX_ACTIONS));
	assign na_ok = (cfg.actions_in_use != 5'd0);

	always_comb begin
		code_d = tql_pkg::STS_OK;
		case (req_in)
			tql_pkg::REQ_TRAIN: begin
				if (!s_ok) code_d = tql_pkg::STS_BAD_STATE;
				else if (!ns_ok) code_d = tql_pkg::STS_BAD_NEXT;
				else if (!a_ok) code_d = tql_pkg::STS_BAD_ACTION;
			end
			tql_pkg::REQ_QUERY: begin
				if (!s_ok) code_d = tql_pkg::STS_BAD_STATE;
				else if (!na_ok) code_d = tql_pkg::STS_BAD_ACTION;
			end
			tql_pkg::REQ_WRITE: begin
				if (!s_ok) code_d = tql_pkg::STS_BAD_STATE;
				else if (!a_ok) code_d = tql_pkg::STS_BAD_ACTION;
			end
			default: code_d = tql_pkg::STS_OK;
		endcase
	end

	// table indices, truncated only once they are known to be in range
	logic [SW+7:0]  s_ext, ns_ext;
	logic [AW+3:0]  a_ext;
	logic [SW-1:0]  s_idx, ns_idx, scan_s;
	logic [AW-1:0]  a_idx;
	logic [ADW-1:0] cur_addr;

	assign s_ext    = {{SW{1'b0}}, s_q};
	assign ns_ext   = {{SW{1'b0}}, ns_q};
	assign a_ext    = {{AW{1'b0}}, a_q};
	assign s_idx    = s_ext[SW-1:0];
	assign ns_idx   = ns_ext[SW-1:0];
	assign a_idx    = a_ext[AW-1:0];
	assign scan_s   = (req_q == tql_pkg::REQ_TRAIN) ? ns_idx : s_idx;
	assign cur_addr = {s_idx, a_idx};
	assign rd_addr  = cmd.rd_cur ? cur_addr : {scan_s, idx_q};

	// train arithmetic, rounding half up is an add then an arithmetic shift
	logic signed [32:0] prod1_rnd;
	logic signed [16:0] disc_term;
	logic signed [17:0] target;
	logic signed [35:0] prod2_rnd;
	logic signed [19:0] delta;
	logic signed [20:0] nv_full;
	logic signed [15:0] nv_sat;

	assign prod1_rnd = prod1_q + 33'sd32768;
	assign disc_term = prod1_rnd[32:16];
	assign target    = 18'(reward_q) + 18'(disc_term);
	assign prod2_rnd = prod2_q + 36'sd32768;
	assign delta     = prod2_rnd[35:16];
	assign nv_full   = 21'(cur_q) + 21'(delta);

	always_comb begin
		if (nv_full > 21'sd32767) nv_sat = 16'sh7FFF;
		else if (nv_full < -21'sd32768) nv_sat = -16'sh8000;
		else nv_sat = nv_full[15:0];
	end

	assign wr_en   = cmd.clear | cmd.write_back | cmd.write_entry;
	assign wr_addr = cmd.clear ? clr_q : cur_addr;
	assign wr_data = cmd.clear ? 16'sd0 : (cmd.write_back ? nv_sat : entry_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.load) idx_q <= '0;
			else if (cmd.scan_issue) idx_q <= idx_q + 1'b1;
			cmp_vld_s1 <= cmd.scan_issue;
			done_q     <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req_in;
			s_q        <= cur_state;
			a_q        <= taken_action;
			ns_q       <= following_state;
			reward_q   <= reward;
			entry_q    <= entry_value;
			code_q     <= code_d;
			best_q     <= 16'sd0;
			best_idx_q <= '0;
			new_q      <= 16'sd0;
		end
		cmp_idx_s1 <= idx_q;
		// first beat of the scan seeds the running maximum
		if (cmp_vld_s1) begin
			if (cmp_idx_s1 == '0 || rd_data_q > best_q) begin
				best_q     <= rd_data_q;
				best_idx_q <= cmp_idx_s1;
			end
		end
		if (cmd.rd_cur) prod1_q <= $signed({1'b0, cfg.discount}) * best_q;
		if (cmd.target) begin
			cur_q  <= rd_data_q;
			diff_q <= 19'(target) - 19'(rd_data_q);
		end
		if (cmd.scale) prod2_q <= $signed({1'b0, cfg.learning_rate}) * diff_q;
		if (cmd.write_back) new_q <= nv_sat;
		if (cmd.write_entry) new_q <= entry_q;
	end

	logic [AW+3:0] best_idx_ext;
	assign best_idx_ext = {4'b0000, best_idx_q};

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q      <= code_q;
			best_action_q <= (req_q == tql_pkg::REQ_QUERY) ? best_idx_ext[3:0] : 4'd0;
			best_value_q  <= best_q;
			new_value_q   <= new_q;
		end
	end

	assign sts.clear_last = (clr_q == {ADW{1'b1}});
	assign sts.scan_last  = (32'(idx_q) + 32'd1 >= 32'(cfg.actions_in_use)) ||
		(32'(idx_q) + 32'd1 >= 32'(MAX_ACTIONS));
	assign sts.err        = (code_q != tql_pkg::STS_OK);
	assign sts.req        = req_q;

	assign done        = done_q;
	assign status      = status_q;
	assign best_action = best_action_q;
	assign best_value  = best_value_q;
	assign new_value   = new_value_q;

endmodule

/* design/tabular_q_learning_update.sv */
`timescale 1ns / 1ps

// tabular q-learning table with train, best-action query and entry write
// requests. a request is taken on start while busy is low; all request
// fields are sampled on that edge. exactly one result beat follows, shown
// for one cycle with done high; the receiver cannot hold it off.
// configuration goes through cfg_write / cfg_index / cfg_data while idle.
// states after accept; done is registered from the finish state:
//   error or unused request code: decide, finish
//   write:                        decide, entry write, finish
//   query:                        decide, scan, scan end, finish
//   train:                        decide, scan, scan end, current read,
//                                 target, scale, write-back, finish
// the scan reads one table entry a cycle through the table's single read
// port, and train then needs two multiplies in sequence before write-back.
// one request is in flight at a time; the next one may be accepted in the
// cycle that done is shown. after reset the table is swept to zero, one
// entry a cycle, busy high, over MAX_STATES * MAX_ACTIONS entries (4096
// at the default size), rounded up to powers of two for each dimension.
module tabular_q_learning_update #(
	parameter int MAX_STATES  = tql_pkg::DEF_MAX_STATES,
	parameter int MAX_ACTIONS = tql_pkg::DEF_MAX_ACTIONS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tql_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tql_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      req_type,
	input  logic [7:0]                      cur_state,
	input  logic [3:0]                      taken_action,
	input  logic signed [15:0]              reward,
	input  logic [7:0]                      following_state,
	input  logic signed [15:0]              entry_value,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [3:0]                      best_action,
	output logic signed [15:0]              best_value,
	output logic signed [15:0]              new_value
);

	tql_pkg::cfg_t    cfg;
	tql_pkg::cmd_t    cmd;
	tql_pkg::dp_sts_t sts;

	tql_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tql_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tql_dp #(
		.MAX_STATES  (MAX_STATES),
		.MAX_ACTIONS (MAX_ACTIONS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req_type),
		.cur_state       (cur_state),
		.taken_action    (taken_action),
		.reward          (reward),
		.following_state (following_state),
		.entry_value     (entry_value),
		.done            (done),
		.status          (status),
		.best_action     (best_action),
		.best_value      (best_value),
		.new_value       (new_value)
	);

endmodule

/* design/tql_check.sv */
`timescale 1ns / 1ps

module tql_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [3:0]         best_action,
	input logic signed [15:0] best_value,
	input logic signed [15:0] new_value
);

	// a result beat only closes a job that was running
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a job in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start a job");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result beat for a job");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != tql_pkg::STS_OK) |->
		(best_action == 4'd0 && best_value == 16'sd0 && new_value == 16'sd0))
		else $error("error result carries non-zero fields");

endmodule

bind tabular_q_learning_update tql_check u_tql_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.best_action (best_action),
	.best_value  (best_value),
	.new_value   (new_value)
);

/* verif/tabular_q_learning_update_test.sv */
`timescale 1ns / 1ps

module tabular_q_learning_update_test;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE_TICKS = 40;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 175;
	localparam int TB_STATES    = tql_pkg::DEF_MAX_STATES;
	localparam int TB_ACTIONS   = tql_pkg::DEF_MAX_ACTIONS;

	typedef struct {
		bit                 is_cfg;
		tql_pkg::reg_idx_t  idx;
		logic [15:0]        data;
		logic [1:0]         req;
		logic [7:0]         s;
		logic [3:0]         a;
		logic signed [15:0] rw;
		logic [7:0]         ns;
		logic signed [15:0] ev;
		int                 gap;
	} job_t;

	typedef struct {
		logic [1:0]         status;
		logic [3:0]         best_action;
		logic signed [15:0] best_value;
		logic signed [15:0] new_value;
	} q_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_write = 1'b0;
	logic [tql_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [tql_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            start = 1'b0;
	logic                            busy;
	logic [1:0]                      req_type = '0;
	logic [7:0]                      cur_state = '0;
	logic [3:0]                      taken_action = '0;
	logic signed [15:0]              reward = '0;
	logic [7:0]                      following_state = '0;
	logic signed [15:0]              entry_value = '0;
	logic                            done;
	logic [1:0]                      status;
	logic [3:0]                      best_action;
	logic signed [15:0]              best_value;
	logic signed [15:0]              new_value;

	tabular_q_learning_update uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.cur_state(cur_state),
		.taken_action(taken_action),
		.reward(reward),
		.following_state(following_state),
		.entry_value(entry_value),
		.done(done),
		.status(status),
		.best_action(best_action),
		.best_value(best_value),
		.new_value(new_value)
	);

	always #2 clk = ~clk;

	// shadow copy of the table and registers
	logic signed [15:0] q_shadow [0:TB_STATES*TB_ACTIONS-1];
	logic [8:0]         shadow_states = tql_pkg::RST_STATES_IN_USE;
	logic [4:0]         shadow_actions = tql_pkg::RST_ACTIONS_IN_USE;
	logic [15:0]        shadow_rate = tql_pkg::RST_LEARNING_RATE;
	logic [15:0]        shadow_discount = tql_pkg::RST_DISCOUNT;

	job_t      pending_jobs [$];
	q_result_t expected_results [$];
	int        errors = 0;
	int        cycle_count = 0;
	int        idle_cycles = 0;
	bit        took_beat = 1'b0;
	bit        block_idle = 1'b0;

	// generator view of the limits that will hold when each job runs
	int gen_s_lim = TB_STATES;
	int gen_a_lim = TB_ACTIONS;
	bit no_gaps = 1'b0;

	function automatic logic signed [15:0] row_peak(int row, int n, output logic [3:0] idx);
		logic signed [15:0] peak;
		peak = q_shadow[row * TB_ACTIONS];
		idx = '0;
		for (int k = 1; k < n; k++) begin
			if (q_shadow[row * TB_ACTIONS + k] > peak) begin
				peak = q_shadow[row * TB_ACTIONS + k];
				idx = k[3:0];
			end
		end
		return peak;
	endfunction

	function automatic q_result_t predict_request(logic [1:0] req, logic [7:0] s, logic [3:0] a,
			logic signed [15:0] rw, logic [7:0] ns, logic signed [15:0] ev);
		q_result_t          r;
		int                 s_lim;
		int                 a_lim;
		int                 slot;
		logic signed [15:0] peak;
		logic signed [15:0] cur;
		logic [3:0]         idx;
		longint             tgt;
		longint             delta;
		longint             sum;
		r = '{status: tql_pkg::STS_OK, best_action: '0, best_value: '0, new_value: '0};
		s_lim = (shadow_states > TB_STATES) ? TB_STATES : int'(shadow_states);
		a_lim = (shadow_actions > TB_ACTIONS) ? TB_ACTIONS : int'(shadow_actions);
		slot = int'(s) * TB_ACTIONS + int'(a);
		case (req)
			tql_pkg::REQ_TRAIN: begin
				if (s >= s_lim) r.status = tql_pkg::STS_BAD_STATE;
				else if (ns >= s_lim) r.status = tql_pkg::STS_BAD_NEXT;
				else if (a >= a_lim) r.status = tql_pkg::STS_BAD_ACTION;
				else begin
					peak = row_peak(ns, a_lim, idx);
					cur = q_shadow[slot];
					// rounding is half up: add half an lsb then shift arithmetically
					tgt = longint'(rw) + ((longint'(shadow_discount) * peak + 32768) >>> 16);
					delta = (longint'(shadow_rate) * (tgt - cur) + 32768) >>> 16;
					sum = cur + delta;
					if (sum > 32767) sum = 32767;
					if (sum < -32768) sum = -32768;
					q_shadow[slot] = sum[15:0];
					r.best_value = peak;
					r.new_value = sum[15:0];
				end
			end
			tql_pkg::REQ_QUERY: begin
				if (s >= s_lim) r.status = tql_pkg::STS_BAD_STATE;
				else if (a_lim == 0) r.status = tql_pkg::STS_BAD_ACTION;
				else r.best_value = row_peak(s, a_lim, r.best_action);
			end
			tql_pkg::REQ_WRITE: begin
				if (s >= s_lim) r.status = tql_pkg::STS_BAD_STATE;
				else if (a >= a_lim) r.status = tql_pkg::STS_BAD_ACTION;
				else begin
					q_shadow[slot] = ev;
					r.new_value = ev;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_field(string what, longint want_v, longint got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
	endtask

	function automatic int pick_gap();
		return no_gaps ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic push_cfg(tql_pkg::reg_idx_t idx, int value);
		job_t j;
		j.is_cfg = 1'b1;
		j.idx = idx;
		j.data = value[15:0];
		j.req = '0;
		j.s = '0;
		j.a = '0;
		j.rw = '0;
		j.ns = '0;
		j.ev = '0;
		j.gap = pick_gap();
		case (idx)
			tql_pkg::REG_STATES_IN_USE:  gen_s_lim = ((value & 511) > TB_STATES) ?
				TB_STATES : (value & 511);
			tql_pkg::REG_ACTIONS_IN_USE: gen_a_lim = ((value & 31) > TB_ACTIONS) ?
				TB_ACTIONS : (value & 31);
			default: ;
		endcase
		pending_jobs = {pending_jobs, j};
	endtask

	task automatic push_req(logic [1:0] req, int s, int a, int rw, int ns, int ev);
		job_t j;
		j.is_cfg = 1'b0;
		j.idx = tql_pkg::REG_STATES_IN_USE;
		j.data = '0;
		j.req = req;
		j.s = s[7:0];
		j.a = a[3:0];
		j.rw = rw[15:0];
		j.ns = ns[7:0];
		j.ev = ev[15:0];
		j.gap = pick_gap();
		pending_jobs = {pending_jobs, j};
	endtask

	// mostly valid states, crowded into a few rows so trains see written values
	function automatic int pick_state();
		int few;
		if (gen_s_lim == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 255);
		few = (gen_s_lim < 6) ? gen_s_lim : 6;
		if ($urandom_range(0, 2) != 0) return $urandom_range(0, few - 1);
		return $urandom_range(0, gen_s_lim - 1);
	endfunction

	function automatic int pick_action();
		if (gen_a_lim == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 15);
		return $urandom_range(0, gen_a_lim - 1);
	endfunction

	function automatic int pick_q88();
		case ($urandom_range(0, 7))
			0: return 32767;
			1: return -32768;
			2: return 0;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pick_fraction();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65535;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic push_random_config();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) push_cfg(tql_pkg::REG_STATES_IN_USE, 0);
		else if (r == 1) push_cfg(tql_pkg::REG_STATES_IN_USE, $urandom_range(257, 511));
		else if (r < 4) push_cfg(tql_pkg::REG_STATES_IN_USE, 1);
		else if (r < 6) push_cfg(tql_pkg::REG_STATES_IN_USE, 256);
		else push_cfg(tql_pkg::REG_STATES_IN_USE, $urandom_range(2, 255));
		r = $urandom_range(0, 19);
		if (r == 0) push_cfg(tql_pkg::REG_ACTIONS_IN_USE, 0);
		else if (r == 1) push_cfg(tql_pkg::REG_ACTIONS_IN_USE, $urandom_range(17, 31));
		else if (r < 4) push_cfg(tql_pkg::REG_ACTIONS_IN_USE, 1);
		else if (r < 8) push_cfg(tql_pkg::REG_ACTIONS_IN_USE, 16);
		else push_cfg(tql_pkg::REG_ACTIONS_IN_USE, $urandom_range(2, 15));
		push_cfg(tql_pkg::REG_LEARNING_RATE, pick_fraction());
		push_cfg(tql_pkg::REG_DISCOUNT, pick_fraction());
	endtask

	task automatic push_random_req();
		int r;
		logic [1:0] req;
		r = $urandom_range(0, 19);
		if (r == 0) req = tql_pkg::REQ_NONE;
		else if (r < 7) req = tql_pkg::REQ_WRITE;
		else if (r < 15) req = tql_pkg::REQ_TRAIN;
		else req = tql_pkg::REQ_QUERY;
		push_req(req, pick_state(), pick_action(), pick_q88(), pick_state(), pick_q88());
	endtask

	// driver: at most one request beat or one register write per falling edge
	always @(negedge clk) begin : feeder
		logic drive_start;
		logic drive_cfg;
		job_t head;
		drive_start = start;
		drive_cfg = 1'b0;
		if (arst_n) begin
			if (start && took_beat) drive_start = 1'b0;
			if (!drive_start && pending_jobs.size() > 0) begin
				head = pending_jobs[0];
				if (idle_cycles < head.gap) begin
					idle_cycles++;
				end else if (!head.is_cfg) begin
					req_type <= head.req;
					cur_state <= head.s;
					taken_action <= head.a;
					reward <= head.rw;
					following_state <= head.ns;
					entry_value <= head.ev;
					drive_start = 1'b1;
					idle_cycles = 0;
					void'(pending_jobs.pop_front());
				end else if (block_idle && expected_results.size() == 0) begin
					// registers change only with the block idle and nothing owed
					cfg_index <= head.idx;
					cfg_data <= head.data;
					drive_cfg = 1'b1;
					idle_cycles = 0;
					void'(pending_jobs.pop_front());
				end
			end
		end
		start <= drive_start;
		cfg_write <= drive_cfg;
	end

	// monitor: register writes, result beats, then newly accepted requests
	always @(posedge clk) begin : watcher
		q_result_t want;
		q_result_t owed;
		if (!arst_n) begin
			took_beat = 1'b0;
			block_idle = 1'b0;
		end else begin
			block_idle = !busy;
			took_beat = start && !busy;
			if (cfg_write) begin
				case (cfg_index)
					tql_pkg::REG_STATES_IN_USE:  shadow_states = cfg_data[8:0];
					tql_pkg::REG_ACTIONS_IN_USE: shadow_actions = cfg_data[4:0];
					tql_pkg::REG_LEARNING_RATE:  shadow_rate = cfg_data;
					tql_pkg::REG_DISCOUNT:       shadow_discount = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, status %0d", $time,
						status);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						flag_field("status", want.status, status);
					if (best_action !== want.best_action)
						flag_field("best_action", want.best_action, best_action);
					if (best_value !== want.best_value)
						flag_field("best_value", want.best_value, best_value);
					if (new_value !== want.new_value)
						flag_field("new_value", want.new_value, new_value);
				end
			end
			if (took_beat) begin
				owed = predict_request(req_type, cur_state, taken_action, reward,
					following_state, entry_value);
				expected_results = {expected_results, owed};
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		foreach (q_shadow[i]) q_shadow[i] = '0;

		// reset values: ties, extremes at the table corners, unused code
		push_req(tql_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
		push_req(tql_pkg::REQ_WRITE, 255, 15, 0, 0, 32767);
		push_req(tql_pkg::REQ_QUERY, 255, 0, 0, 0, 0);
		push_req(tql_pkg::REQ_WRITE, 0, 0, 0, 0, -32768);
		push_req(tql_pkg::REQ_TRAIN, 0, 0, 32767, 255, 0);
		push_req(tql_pkg::REQ_TRAIN, 255, 15, -32768, 0, 0);
		push_req(tql_pkg::REQ_NONE, 255, 15, -1, 255, -1);
		push_req(tql_pkg::REQ_WRITE, 7, 3, 0, 0, -1);
		push_req(tql_pkg::REQ_QUERY, 7, 0, 0, 0, 0);

		// small limits: every error code and the order of the checks
		push_cfg(tql_pkg::REG_STATES_IN_USE, 10);
		push_cfg(tql_pkg::REG_ACTIONS_IN_USE, 4);
		push_cfg(tql_pkg::REG_LEARNING_RATE, 65535);
		push_cfg(tql_pkg::REG_DISCOUNT, 65535);
		push_req(tql_pkg::REQ_TRAIN, 10, 15, 0, 200, 0);
		push_req(tql_pkg::REQ_TRAIN, 1, 0, 0, 10, 0);
		push_req(tql_pkg::REQ_TRAIN, 1, 4, 0, 2, 0);
		push_req(tql_pkg::REQ_QUERY, 200, 0, 0, 0, 0);
		push_req(tql_pkg::REQ_WRITE, 10, 0, 0, 0, 5);
		push_req(tql_pkg::REQ_WRITE, 3, 4, 0, 0, 5);
		push_req(tql_pkg::REQ_WRITE, 2, 3, 0, 0, 32767);
		push_req(tql_pkg::REQ_TRAIN, 2, 3, 32767, 2, 0);
		push_req(tql_pkg::REQ_WRITE, 1, 0, 0, 0, -32768);
		push_req(tql_pkg::REQ_TRAIN, 1, 0, -32768, 1, 0);

		// zero counts reject everything
		push_cfg(tql_pkg::REG_STATES_IN_USE, 0);
		push_cfg(tql_pkg::REG_ACTIONS_IN_USE, 0);
		push_req(tql_pkg::REQ_TRAIN, 0, 0, 0, 0, 0);
		push_req(tql_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
		push_cfg(tql_pkg::REG_STATES_IN_USE, 5);
		push_req(tql_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
		push_req(tql_pkg::REQ_TRAIN, 0, 0, 0, 0, 0);
		push_req(tql_pkg::REQ_WRITE, 0, 0, 0, 0, 1);

		// counts above the table size, zero rates
		push_cfg(tql_pkg::REG_STATES_IN_USE, 511);
		push_cfg(tql_pkg::REG_ACTIONS_IN_USE, 31);
		push_cfg(tql_pkg::REG_LEARNING_RATE, 0);
		push_cfg(tql_pkg::REG_DISCOUNT, 0);
		push_req(tql_pkg::REQ_TRAIN, 255, 15, 100, 255, 0);
		push_req(tql_pkg::REQ_QUERY, 255, 0, 0, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			push_random_config();
			for (int n = 0; n < PHASE_ITEMS; n++) push_random_req();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_jobs.size() != 0 || start) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
